// ----- rtl/shell_command_tokenizer_defines.svh -----
// assertion macros used by the checker file
`ifndef SHELL_COMMAND_TOKENIZER_DEFINES_SVH
`define SHELL_COMMAND_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SCT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define SCT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sct_pkg.sv -----
`default_nettype none

package sct_pkg;

    // character codes the lexer reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    // status codes on a result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_GT_LT    = 2'd1;
    localparam logic [1:0] ST_UNSUPP   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // token kinds
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_OP   = 1'b1;

    // word length counter width
    localparam int WLEN_W = 7;

    // room for the results of one byte, and queue depth between front and back
    localparam int MAX_RES = 3;
    localparam int RES_IDX_W = 2;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // operator waiting for its second byte
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_GT   = 2'd1,
        PEND_LT   = 2'd2
    } pend_t;

    // one result as it leaves the block, minus the last mark
    typedef struct packed {
        logic [7:0] tbyte;
        logic       first;
        logic       fin;
        logic       kind;
        logic [1:0] status;
        logic       done;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [RES_IDX_W-1:0]     cnt;
        res_t [MAX_RES-1:0]       res;
    } q_entry_t;

    // queue control from the front
    typedef struct packed {
        logic push;
    } q_ctl_t;

    function automatic res_t mk_res(input logic [7:0] b, input logic first,
                                    input logic fin, input logic kind,
                                    input logic [1:0] status, input logic done);
        res_t r;
        r.tbyte  = b;
        r.first  = first;
        r.fin    = fin;
        r.kind   = kind;
        r.status = status;
        r.done   = done;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sct_front.sv -----
`default_nettype none

module sct_front
    import sct_pkg::*;
#(
    parameter int MAX_WORD_LEN = 99
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    output q_ctl_t          ctl,
    output q_entry_t        entry
);

    localparam logic [WLEN_W-1:0] MAX_LEN = WLEN_W'(MAX_WORD_LEN);

    logic [7:0]        held_char_reg, held_char_next;
    logic              held_valid_reg, held_valid_next;
    logic              held_starts_reg, held_starts_next;
    logic [WLEN_W-1:0] wlen_reg, wlen_next;
    pend_t             pend_reg, pend_next;
    logic              discard_reg, discard_next;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg   <= '0;
            held_valid_reg  <= 1'b0;
            held_starts_reg <= 1'b0;
            wlen_reg        <= '0;
            pend_reg        <= PEND_NONE;
            discard_reg     <= 1'b0;
        end
        else if (accept)
        begin
            held_char_reg   <= held_char_next;
            held_valid_reg  <= held_valid_next;
            held_starts_reg <= held_starts_next;
            wlen_reg        <= wlen_next;
            pend_reg        <= pend_next;
            discard_reg     <= discard_next;
        end
    end

    // classify the byte and build every result it causes
    always_comb
    begin
        logic [RES_IDX_W-1:0] n;
        logic                 do_plain;
        logic                 is_sep;
        n                = '0;
        do_plain         = 1'b0;
        entry            = '0;
        held_char_next   = held_char_reg;
        held_valid_next  = held_valid_reg;
        held_starts_next = held_starts_reg;
        wlen_next        = wlen_reg;
        pend_next        = pend_reg;
        discard_next     = discard_reg;
        is_sep           = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

        if (discard_reg)
        begin
            // drop bytes until the line ends
            if (in_byte == CH_NUL)
            begin
                entry.res[n] = mk_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, ST_OK, 1'b1);
                n = n + 1'b1;
                held_char_next   = '0;
                held_valid_next  = 1'b0;
                held_starts_next = 1'b0;
                wlen_next        = '0;
                pend_next        = PEND_NONE;
                discard_next     = 1'b0;
            end
        end
        else if (pend_reg == PEND_GT)
        begin
            pend_next = PEND_NONE;
            if (in_byte == CH_GT || in_byte == CH_AMP)
            begin
                entry.res[n] = mk_res(CH_GT, 1'b1, 1'b0, KIND_OP, ST_OK, 1'b0);
                n = n + 1'b1;
                entry.res[n] = mk_res(in_byte, 1'b0, 1'b1, KIND_OP, ST_OK, 1'b0);
                n = n + 1'b1;
            end
            else if (in_byte == CH_LT)
            begin
                entry.res[n] = mk_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, ST_GT_LT, 1'b0);
                n = n + 1'b1;
                held_valid_next  = 1'b0;
                held_starts_next = 1'b0;
                wlen_next        = '0;
                discard_next     = 1'b1;
            end
            else
            begin
                entry.res[n] = mk_res(CH_GT, 1'b1, 1'b1, KIND_OP, ST_OK, 1'b0);
                n = n + 1'b1;
                do_plain = 1'b1;
            end
        end
        else if (pend_reg == PEND_LT)
        begin
            pend_next = PEND_NONE;
            if (in_byte == CH_LT || in_byte == CH_AMP)
            begin
                entry.res[n] = mk_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, ST_UNSUPP, 1'b0);
                n = n + 1'b1;
                held_valid_next  = 1'b0;
                held_starts_next = 1'b0;
                wlen_next        = '0;
                discard_next     = 1'b1;
            end
            else
            begin
                entry.res[n] = mk_res(CH_LT, 1'b1, 1'b1, KIND_OP, ST_OK, 1'b0);
                n = n + 1'b1;
                do_plain = 1'b1;
            end
        end
        else
        begin
            pend_next = PEND_NONE;
            do_plain  = 1'b1;
        end

        // byte with no operator pending on a live line
        if (do_plain)
        begin
            if (in_byte == CH_NUL || is_sep || in_byte == CH_PIPE || in_byte == CH_AMP
                || in_byte == CH_GT || in_byte == CH_LT || wlen_reg >= MAX_LEN)
            begin
                // close the current word
                if (held_valid_reg)
                begin
                    entry.res[n] = mk_res(held_char_reg, held_starts_reg, 1'b1,
                                          KIND_WORD, ST_OK, 1'b0);
                    n = n + 1'b1;
                end
                held_valid_next  = 1'b0;
                held_starts_next = 1'b0;
                wlen_next        = '0;

                if (in_byte == CH_NUL)
                begin
                    entry.res[n] = mk_res(CH_NUL, 1'b0, 1'b0, KIND_WORD, ST_OK, 1'b1);
                    n = n + 1'b1;
                    held_char_next = '0;
                    pend_next      = PEND_NONE;
                    discard_next   = 1'b0;
                end
                else if (in_byte == CH_PIPE || in_byte == CH_AMP)
                begin
                    entry.res[n] = mk_res(in_byte, 1'b1, 1'b1, KIND_OP, ST_OK, 1'b0);
                    n = n + 1'b1;
                end
                else if (in_byte == CH_GT)
                begin
                    pend_next = PEND_GT;
                end
                else if (in_byte == CH_LT)
                begin
                    pend_next = PEND_LT;
                end
                else if (!is_sep)
                begin
                    // word too long
                    entry.res[n] = mk_res(CH_NUL, 1'b0, 1'b0, KIND_WORD,
                                          ST_OVERFLOW, 1'b0);
                    n = n + 1'b1;
                    pend_next    = PEND_NONE;
                    discard_next = 1'b1;
                end
            end
            else
            begin
                // word byte: release the previous one, hold this one
                if (held_valid_reg)
                begin
                    entry.res[n] = mk_res(held_char_reg, held_starts_reg, 1'b0,
                                          KIND_WORD, ST_OK, 1'b0);
                    n = n + 1'b1;
                end
                held_char_next   = in_byte;
                held_valid_next  = 1'b1;
                held_starts_next = (wlen_reg == '0);
                wlen_next        = wlen_reg + 1'b1;
            end
        end

        entry.cnt = n;
        ctl.push  = accept && (n != '0);
    end

endmodule

`default_nettype wire

// ----- rtl/sct_queue.sv -----
`default_nettype none

module sct_queue
    import sct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  q_ctl_t    ctl,
    input  q_entry_t  push_entry,
    output logic      full,
    output logic      head_valid,
    output q_entry_t  head_entry,
    input  wire logic pop
);

    q_entry_t                mem [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W:0]         cnt_reg, cnt_next;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({ctl.push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    assign full       = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/sct_back.sv -----
`default_nettype none

module sct_back
    import sct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  q_entry_t        head_entry,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      token_byte,
    output logic            token_first,
    output logic            token_final,
    output logic            token_kind,
    output logic [1:0]      status,
    output logic            line_done,
    output logic            last_result
);

    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 res_reg;
    logic                 last_reg;
    logic                 load;
    logic                 is_last;
    res_t                 cur;

    // pick the next result of the head transaction
    always_comb
    begin
        load     = head_valid && (!out_valid_reg || out_ready);
        cur      = head_entry.res[idx_reg];
        is_last  = (idx_reg == head_entry.cnt - 1'b1);
        pop      = load && is_last;
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= cur;
            last_reg <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign token_byte  = res_reg.tbyte;
    assign token_first = res_reg.first;
    assign token_final = res_reg.fin;
    assign token_kind  = res_reg.kind;
    assign status      = res_reg.status;
    assign line_done   = res_reg.done;
    assign last_result = last_reg;

endmodule

`default_nettype wire

// ----- rtl/shell_command_tokenizer.sv -----
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_ready  | in_byte
// output   | out_valid / out_ready| token_byte token_first token_final token_kind
//          |                      | status line_done last_result
//
// one byte accepted per cycle while in_ready is high; the back end drains one
// result per cycle from a 4-entry queue while the output is not stalled
// in_ready drops only while that queue is full
// the output register holds a result while out_ready is low
// rst_n clears lexer state, queue pointers and output valid at once
`default_nettype none

module shell_command_tokenizer
    import sct_pkg::*;
#(
    parameter int MAX_WORD_LEN = 99
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      token_byte,
    output logic            token_first,
    output logic            token_final,
    output logic            token_kind,
    output logic [1:0]      status,
    output logic            line_done,
    output logic            last_result
);

    q_ctl_t   ctl;
    q_entry_t push_entry;
    q_entry_t head_entry;
    logic     q_full;
    logic     head_valid;
    logic     pop;
    logic     accept;

    // input transaction
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    sct_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .ctl     (ctl),
        .entry   (push_entry)
    );

    sct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    sct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_byte  (token_byte),
        .token_first (token_first),
        .token_final (token_final),
        .token_kind  (token_kind),
        .status      (status),
        .line_done   (line_done),
        .last_result (last_result)
    );

endmodule

`default_nettype wire

// ----- rtl/sct_checker.sv -----
`default_nettype none
`include "shell_command_tokenizer_defines.svh"

module sct_checker
    import sct_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] token_byte,
    input wire logic       token_first,
    input wire logic       token_final,
    input wire logic       token_kind,
    input wire logic [1:0] status,
    input wire logic       line_done,
    input wire logic       last_result
);

    // a stalled result keeps its payload
    `SCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_byte) && $stable(status) && $stable(last_result), "output changed while stalled")

    // line marker is clean and ends its transaction
    `SCT_ASSERT_NOW(a_marker, clk, rst_n, out_valid && line_done, last_result && token_byte == CH_NUL && status == ST_OK && !token_first && !token_final, "bad line marker")

    // an error result is the last one of its byte and carries no token
    `SCT_ASSERT_NOW(a_error, clk, rst_n, out_valid && status != ST_OK, last_result && !line_done && token_byte == CH_NUL && !token_first, "bad error result")

    // a pipe is always a one-byte operator
    `SCT_ASSERT_NOW(a_pipe, clk, rst_n, out_valid && token_kind == KIND_OP && token_byte == CH_PIPE, token_first && token_final, "pipe not a single-byte operator")

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_byte  (token_byte),
    .token_first (token_first),
    .token_final (token_final),
    .token_kind  (token_kind),
    .status      (status),
    .line_done   (line_done),
    .last_result (last_result)
);

`default_nettype wire

// ----- verif/shell_command_tokenizer_tb.sv -----
`default_nettype none

module shell_command_tokenizer_tb;
    import sct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_LIMIT = 99;
    localparam int RANDOM_BYTES = 20;

    // one expected or observed result transaction
    typedef struct packed {
        logic [7:0] tbyte;
        logic       first;
        logic       fin;
        logic       kind;
        logic [1:0] st;
        logic       done;
        logic       last;
    } token_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] token_byte;
    logic       token_first;
    logic       token_final;
    logic       token_kind;
    logic [1:0] status;
    logic       line_done;
    logic       last_result;

    // lexer state as the predictor sees it
    logic [7:0]        held_byte;
    logic              held_live;
    logic              held_first;
    logic [WLEN_W-1:0] word_len;
    pend_t             pend_op;
    logic              dropping;

    token_beat_t token_q[$];   // results still owed by the block, oldest first
    token_beat_t beat_q[$];    // results of the byte being predicted

    logic calm;                // no idling on either side while set
    int   mismatches;
    int   bytes_taken;
    int   results_seen;
    int   lines_seen;
    int   error_beats;

    shell_command_tokenizer #(
        .MAX_WORD_LEN (WORD_LIMIT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_byte  (token_byte),
        .token_first (token_first),
        .token_final (token_final),
        .token_kind  (token_kind),
        .status      (status),
        .line_done   (line_done),
        .last_result (last_result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("shell_command_tokenizer_tb NOT OK");
        $finish;
    end

    function automatic token_beat_t beat(input logic [7:0] b, input logic f, input logic fin,
                                         input logic k, input logic [1:0] s, input logic d);
        token_beat_t r;
        r.tbyte = b;
        r.first = f;
        r.fin   = fin;
        r.kind  = k;
        r.st    = s;
        r.done  = d;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c == CH_NUL || c == CH_TAB || c == CH_SPACE || c == CH_AMP ||
               c == CH_LT || c == CH_GT || c == CH_PIPE;
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_special(c));
        return c;
    endfunction

    task automatic clear_line();
        held_byte  = 8'h00;
        held_live  = 1'b0;
        held_first = 1'b0;
        word_len   = '0;
        pend_op    = PEND_NONE;
        dropping   = 1'b0;
    endtask

    // held word byte goes out as the end of its word
    task automatic close_word();
        if (held_live)
            beat_q.push_back(beat(held_byte, held_first, 1'b1, KIND_WORD, ST_OK, 1'b0));
        held_live  = 1'b0;
        held_first = 1'b0;
        word_len   = '0;
    endtask

    // error result, then the rest of the line is ignored
    task automatic abort_line(input logic [1:0] code);
        beat_q.push_back(beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, code, 1'b0));
        held_live  = 1'b0;
        held_first = 1'b0;
        word_len   = '0;
        pend_op    = PEND_NONE;
        dropping   = 1'b1;
    endtask

    // byte with no operator pending on a live line
    task automatic take_plain(input logic [7:0] b);
        logic starts;
        if (b == CH_NUL)
        begin
            close_word();
            beat_q.push_back(beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, ST_OK, 1'b1));
            clear_line();
        end
        else if (b == CH_SPACE || b == CH_TAB)
            close_word();
        else if (b == CH_PIPE || b == CH_AMP)
        begin
            close_word();
            beat_q.push_back(beat(b, 1'b1, 1'b1, KIND_OP, ST_OK, 1'b0));
        end
        else if (b == CH_GT || b == CH_LT)
        begin
            close_word();
            pend_op = (b == CH_GT) ? PEND_GT : PEND_LT;
        end
        else if (word_len >= WORD_LIMIT)
        begin
            close_word();
            abort_line(ST_OVERFLOW);
        end
        else
        begin
            starts = (word_len == 0);
            if (held_live)
                beat_q.push_back(beat(held_byte, held_first, 1'b0, KIND_WORD, ST_OK, 1'b0));
            held_byte  = b;
            held_live  = 1'b1;
            held_first = starts;
            word_len   = word_len + 1'b1;
        end
    endtask

    // work out the results of one accepted byte and queue them
    task automatic predict_byte(input logic [7:0] b);
        beat_q.delete();
        if (dropping)
        begin
            if (b == CH_NUL)
            begin
                beat_q.push_back(beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, ST_OK, 1'b1));
                clear_line();
            end
        end
        else if (pend_op == PEND_GT)
        begin
            pend_op = PEND_NONE;
            if (b == CH_GT || b == CH_AMP)
            begin
                beat_q.push_back(beat(CH_GT, 1'b1, 1'b0, KIND_OP, ST_OK, 1'b0));
                beat_q.push_back(beat(b, 1'b0, 1'b1, KIND_OP, ST_OK, 1'b0));
            end
            else if (b == CH_LT)
                abort_line(ST_GT_LT);
            else
            begin
                beat_q.push_back(beat(CH_GT, 1'b1, 1'b1, KIND_OP, ST_OK, 1'b0));
                take_plain(b);
            end
        end
        else if (pend_op == PEND_LT)
        begin
            pend_op = PEND_NONE;
            if (b == CH_LT || b == CH_AMP)
                abort_line(ST_UNSUPP);
            else
            begin
                beat_q.push_back(beat(CH_LT, 1'b1, 1'b1, KIND_OP, ST_OK, 1'b0));
                take_plain(b);
            end
        end
        else
            take_plain(b);

        if (beat_q.size() > 0)
            beat_q[beat_q.size() - 1].last = 1'b1;
        foreach (beat_q[i])
            token_q.push_back(beat_q[i]);
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_beat();
        token_beat_t got;
        token_beat_t want;
        got = {token_byte, token_first, token_final, token_kind, status, line_done,
               last_result};
        if (token_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: byte=%h first=%b final=%b kind=%b status=%0d done=%b last=%b",
                         got.tbyte, got.first, got.fin, got.kind, got.st, got.done, got.last);
        end
        else
        begin
            want = token_q.pop_front();
            results_seen++;
            if (got.tbyte !== want.tbyte || got.first !== want.first ||
                got.fin !== want.fin || got.kind !== want.kind || got.st !== want.st ||
                got.done !== want.done || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at result %0d:", results_seen);
                    $display("  expected byte=%h first=%b final=%b kind=%b status=%0d done=%b last=%b",
                             want.tbyte, want.first, want.fin, want.kind, want.st,
                             want.done, want.last);
                    $display("  actual   byte=%h first=%b final=%b kind=%b status=%0d done=%b last=%b",
                             got.tbyte, got.first, got.fin, got.kind, got.st, got.done, got.last);
                end
            end
            if (want.done)
                lines_seen++;
            if (want.st != ST_OK)
                error_beats++;
        end
    endtask

    // input monitor, output stall and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(99) >= 21);
            if (in_valid && in_ready)
            begin
                predict_byte(in_byte);
                bytes_taken++;
            end
            if (out_valid && out_ready)
                check_beat();
        end
    end

    // one input transaction, with random idle cycles in front
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    // hold off the sender until every owed result has come out
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (token_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // words, separators, every operator, operator left pending at line end
    task automatic test_words_and_operators();
        send_line("a b\t|c&d");
        send_line(">>x>&y>");
        send_line("<z> w>|");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_NUL);
        send_byte(CH_NUL);
        wait_all_results();
    endtask

    // >< and << and <& errors, with the rest of each line dropped
    task automatic test_operator_errors();
        send_line("q><k|");
        send_line("<<>a");
        send_line("ab<&");
        wait_all_results();
    endtask

    // a word right at the limit, then one past it
    task automatic test_word_limit();
        for (int k = 0; k < WORD_LIMIT; k++)
            send_byte(word_char());
        send_byte(CH_SPACE);
        for (int k = 0; k <= WORD_LIMIT; k++)
            send_byte(word_char());
        send_byte(CH_GT);
        send_byte(word_char());
        send_byte(CH_NUL);
        wait_all_results();
    endtask

    task automatic send_random_line();
        int parts;
        int n;
        parts = $urandom_range(1, 6);
        for (int p = 0; p < parts; p++)
        begin
            case ($urandom_range(9))
                5:
                    repeat ($urandom_range(1, 2))
                        send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
                6, 7:
                    case ($urandom_range(5))
                        0: send_byte(CH_PIPE);
                        1: send_byte(CH_AMP);
                        2: send_byte(CH_GT);
                        3: send_byte(CH_LT);
                        4: begin send_byte(CH_GT); send_byte(CH_GT); end
                        default: begin send_byte(CH_GT); send_byte(CH_AMP); end
                    endcase
                8:
                    case ($urandom_range(2))
                        0: begin send_byte(CH_GT); send_byte(CH_LT); end
                        1: begin send_byte(CH_LT); send_byte(CH_LT); end
                        default: begin send_byte(CH_LT); send_byte(CH_AMP); end
                    endcase
                9:
                    send_byte(8'($urandom_range(1, 255)));
                default:
                begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(95, 104)
                                                  : $urandom_range(1, 8);
                    repeat (n)
                        send_byte(word_char());
                end
            endcase
        end
        send_byte(CH_NUL);
    endtask

    // mostly well-formed lines with random content, some raw noise
    task automatic test_random_lines();
        int stop_at;
        int calm_until;
        logic drained;
        stop_at    = bytes_taken + RANDOM_BYTES;
        calm_until = bytes_taken + 60;
        drained    = 1'b0;
        calm       = 1'b1;
        while (bytes_taken < stop_at)
        begin
            if (bytes_taken >= calm_until)
                calm = 1'b0;
            if (!drained && bytes_taken >= stop_at - RANDOM_BYTES / 2)
            begin
                wait_all_results();
                drained = 1'b1;
            end
            if ($urandom_range(99) < 85)
                send_random_line();
            else
            begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_NUL);
            end
        end
        calm = 1'b0;
        wait_all_results();
    endtask

    initial
    begin
        in_valid    <= 1'b0;
        in_byte     <= 8'h00;
        out_ready   <= 1'b0;
        rst_n       <= 1'b0;
        calm         = 1'b0;
        mismatches   = 0;
        bytes_taken  = 0;
        results_seen = 0;
        lines_seen   = 0;
        error_beats  = 0;
        clear_line();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_words_and_operators();
        test_operator_errors();
        test_word_limit();
        test_random_lines();

        // let any stray result show up
        repeat (20) @(posedge clk);
        if (token_q.size() != 0)
        begin
            $display("%0d expected results never arrived", token_q.size());
            mismatches += token_q.size();
        end

        $display("run covered %0d input bytes, %0d results checked, %0d lines closed",
                 bytes_taken, results_seen, lines_seen);
        $display("error results seen: %0d, mismatches: %0d", error_beats, mismatches);
        if (mismatches == 0)
            $display("shell_command_tokenizer_tb OK");
        else
            $display("shell_command_tokenizer_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/sct_pkg.sv
rtl/sct_front.sv
rtl/sct_queue.sv
rtl/sct_back.sv
rtl/shell_command_tokenizer.sv
rtl/sct_checker.sv
verif/shell_command_tokenizer_tb.sv
